@@ hdl/scls_pkg.sv @@
// shared types and constants for the level sensor unit
`timescale 1ns / 1ps
package scls_pkg;
	localparam int unsigned WindowDepthDef = 5;
	localparam int unsigned MarginUnits = 15;
	localparam int unsigned AcceptHits = 5;
	localparam int unsigned MissLimit = 20;
	localparam int unsigned MinSpanUnits = 250;
	localparam logic [31:0] GateMs = 32'd30000;
	localparam int unsigned EmptyMark = 200;
	localparam int unsigned FullScale = 10000;
	localparam int unsigned DivBits = 36;

	typedef enum logic [2:0] {
		REG_PLAUS_LOW = 3'd0,
		REG_PLAUS_HIGH = 3'd1,
		REG_SEED_LOW = 3'd2,
		REG_SEED_HIGH = 3'd3,
		REG_INVERT = 3'd4,
		REG_TOTAL = 3'd5,
		REG_RESERVE = 3'd6
	} reg_idx_t;

	// divider request and answer
	typedef struct packed {
		logic start;
		logic [DivBits-1:0] dividend;
		logic [DivBits-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DivBits-1:0] quotient;
	} div_rsp_t;
endpackage

@@ hdl/scls_divider.sv @@
// bit-serial unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module scls_divider
	import scls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int unsigned CntW = $clog2(DivBits + 1);

	logic [DivBits-1:0] rem_q;
	logic [DivBits-1:0] quo_q;
	logic [DivBits-1:0] den_q;
	logic [CntW-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DivBits:0]   trial;

	assign trial = {rem_q, quo_q[DivBits-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(DivBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[DivBits]) begin
				rem_q <= trial[DivBits-1:0];
				quo_q <= {quo_q[DivBits-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DivBits-2:0], quo_q[DivBits-1]};
				quo_q <= {quo_q[DivBits-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

`ifndef SYNTH
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("divider did not start");
`endif
endmodule

@@ hdl/self_calibrating_level_sensor_unit.sv @@
// top level of the self-calibrating resistive level sensor
// a valid sample runs serial median insertion, learn, range, map, map division, ema, out, reserve
// and volume to m_tvalid; reserve division only with a reserve, map division not on a zero span
// a rejected sample with a held level runs only the reserve and volume steps; none held: no result
// one sample in flight; the next transaction is taken the cycle after the result handshake
// arst_n clears all control and learned state; the ring needs no clearing
`timescale 1ns / 1ps
module self_calibrating_level_sensor_unit
	import scls_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = WindowDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// resistance[15:0], sample_ok[16], time_ms[48:17], zero fill
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// level_hundredths[13:0], volume_out[29:14], volume_valid[30],
	// almost_empty[31], calibrated[32], learned_low[48:33], learned_high[64:49]
	output logic [71:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	localparam int unsigned PosW = $clog2(WINDOW_DEPTH);
	localparam int unsigned FillW = $clog2(WINDOW_DEPTH + 1);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_SORT  = 12'b000000000010,
		ST_LEARN = 12'b000000000100,
		ST_RANGE = 12'b000000001000,
		ST_MAP   = 12'b000000010000,
		ST_MDIV  = 12'b000000100000,
		ST_EMA   = 12'b000001000000,
		ST_RSV   = 12'b000010000000,
		ST_RDIV  = 12'b000100000000,
		ST_VOL   = 12'b001000000000,
		ST_VDIV  = 12'b010000000000,
		ST_OUT   = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [15:0] plow_q, phigh_q, slow_q, shigh_q, total_q, rsv_q;
	logic        inv_q;

	logic [15:0] ring_q [WINDOW_DEPTH];
	logic [15:0] sorted_q [WINDOW_DEPTH];
	logic [FillW-1:0] fill_q;
	logic [PosW-1:0]  pos_q;
	logic [FillW-1:0] sidx_q;

	logic [13:0] smooth_q;
	logic        svalid_q, cal_q;
	logic [15:0] rlow_q, rhigh_q, clow_q, chigh_q;
	logic [2:0]  clh_q, chh_q, boot_q;
	logic [4:0]  clm_q, chm_q;
	logic [31:0] llt_q, lht_q;

	logic [15:0] med_q;
	logic [31:0] now_q;
	logic        neg_q;
	logic [15:0] emin_q;
	logic [16:0] span_q;
	logic [13:0] lvl_q, olvl_q;
	logic [15:0] ovol_q;

	div_req_t dreq;
	div_rsp_t drsp;
	scls_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [15:0] in_r;
	logic        in_ok, accept, plaus;
	logic [31:0] in_t;
	assign in_r = s_tdata[15:0];
	assign in_ok = s_tdata[16];
	assign in_t = s_tdata[48:17];
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign accept = s_tvalid && s_tready;
	assign plaus = in_ok && in_r >= plow_q && in_r <= phigh_q;

	// serial insertion: one ring entry per cycle into a sorted line
	logic [15:0] ins_v;
	logic [PosW-1:0] ins_idx;
	logic [FillW-1:0] nfill;
	assign ins_idx = sidx_q[PosW-1:0];
	assign ins_v = ring_q[ins_idx];
	assign nfill = (fill_q < FillW'(WINDOW_DEPTH)) ? fill_q + 1'b1 : fill_q;

	// learning
	logic glow, ghigh;
	logic signed [17:0] smed, srl, srh;
	assign glow = (llt_q == 32'd0) || ((now_q - llt_q) >= GateMs);
	assign ghigh = (lht_q == 32'd0) || ((now_q - lht_q) >= GateMs);
	assign smed = 18'(med_q);
	assign srl = 18'(rlow_q) - 18'(MarginUnits);
	assign srh = 18'(rhigh_q) + 18'(MarginUnits);

	// range selection
	logic [15:0] emin, emax;
	logic [16:0] rspan;
	assign rspan = 17'(rhigh_q) - 17'(rlow_q);
	always_comb begin
		if (cal_q && !rspan[16] && rspan >= 17'(MinSpanUnits)) begin
			emin = rlow_q;
			emax = rhigh_q;
		end else if (cal_q) begin
			emin = (rlow_q < slow_q) ? rlow_q : slow_q;
			emax = (rhigh_q > shigh_q) ? rhigh_q : shigh_q;
		end else begin
			emin = slow_q;
			emax = shigh_q;
		end
	end

	// signed mapping with magnitudes into the unsigned divider
	logic signed [17:0] num, den;
	logic [17:0] anum, aden;
	assign num = 18'(med_q) - 18'(emin_q);
	assign den = 18'(signed'(span_q));
	assign anum = num[17] ? 18'(-num) : 18'(num);
	assign aden = den[17] ? 18'(-den) : 18'(den);

	logic signed [16:0] q_s, lv_s;
	logic [35:0] qmag;
	logic [13:0] mlvl;
	always_comb begin
		qmag = drsp.quotient;
		if (qmag > 36'd20000) qmag = 36'd20000;
		q_s = neg_q ? -17'(qmag[15:0]) : 17'(qmag[15:0]);
		if (q_s < -17'sd10000) q_s = -17'sd10000;
		if (span_q == 17'd0) q_s = '0;
		lv_s = inv_q ? 17'sd10000 - q_s : q_s;
		if (lv_s < 0) mlvl = '0;
		else if (lv_s > 17'sd10000) mlvl = 14'(FullScale);
		else mlvl = lv_s[13:0];
	end

	// ema step: 35*|diff|/100 as (7*|diff|/4)/5, the /5 by reciprocal multiply
	logic signed [14:0] diff;
	logic [13:0] dmag;
	logic [16:0] d7;
	logic [31:0] recip;
	logic [13:0] step;
	assign diff = 15'(lvl_q) - 15'(smooth_q);
	assign dmag = diff[14] ? 14'(-diff) : 14'(diff);
	assign d7 = 17'(dmag) * 17'd7;
	assign recip = 32'(d7[16:2]) * 32'd26215;
	assign step = 14'(recip >> 17);

	logic rsv_on;
	assign rsv_on = (total_q != 16'd0) && (rsv_q != 16'd0) && (rsv_q < total_q);

	always_comb begin
		dreq = '0;
		unique case (state_q)
			ST_MAP: begin
				dreq.start = span_q != 17'd0;
				dreq.dividend = 36'(anum) * 36'd10000;
				dreq.divisor = 36'(aden);
			end
			ST_RSV: begin
				dreq.start = rsv_on;
				dreq.dividend = 36'(rsv_q) * 36'd10000 + 36'(smooth_q) * 36'(total_q - rsv_q);
				dreq.divisor = 36'(total_q);
			end
			ST_VOL: begin
				dreq.start = 1'b1;
				dreq.dividend = 36'(olvl_q) * 36'(total_q);
				dreq.divisor = 36'd10000;
			end
			default: dreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plow_q <= 16'd0; phigh_q <= 16'hFFFF; slow_q <= 16'd0;
			shigh_q <= 16'd1900; inv_q <= 1'b0; total_q <= 16'd0; rsv_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLAUS_LOW:  plow_q <= cfg_wdata;
				REG_PLAUS_HIGH: phigh_q <= cfg_wdata;
				REG_SEED_LOW:   slow_q <= cfg_wdata;
				REG_SEED_HIGH:  shigh_q <= cfg_wdata;
				REG_INVERT:     inv_q <= cfg_wdata[0];
				REG_TOTAL:      total_q <= cfg_wdata;
				REG_RESERVE:    rsv_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && plaus) ring_q[pos_q] <= in_r;
		if (state_q == ST_SORT && sidx_q < fill_q) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				if (FillW'(i) <= sidx_q) begin
					if (i == 0) begin
						if (sorted_q[0] > ins_v || sidx_q == 0) sorted_q[0] <= (sidx_q == 0 || sorted_q[0] > ins_v) ? ins_v : sorted_q[0];
					end else if (FillW'(i) == sidx_q) begin
						sorted_q[i] <= (sorted_q[i-1] > ins_v) ? sorted_q[i-1] : ins_v;
					end else begin
						if (sorted_q[i-1] > ins_v) sorted_q[i] <= sorted_q[i-1];
						else if (sorted_q[i] > ins_v) sorted_q[i] <= ins_v;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			fill_q <= '0; pos_q <= '0; sidx_q <= '0;
			smooth_q <= '0; svalid_q <= 1'b0; cal_q <= 1'b0;
			rlow_q <= '0; rhigh_q <= '0; clow_q <= '0; chigh_q <= '0;
			clh_q <= '0; chh_q <= '0; clm_q <= '0; chm_q <= '0; boot_q <= '0;
			llt_q <= '0; lht_q <= '0;
			med_q <= '0; now_q <= '0; neg_q <= 1'b0; emin_q <= '0; span_q <= '0;
			lvl_q <= '0; olvl_q <= '0; ovol_q <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) begin
					now_q <= in_t;
					if (plaus) begin
						pos_q <= (pos_q == PosW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;
						fill_q <= nfill;
						sidx_q <= '0;
						state_q <= ST_SORT;
					end else if (svalid_q) begin
						state_q <= ST_RSV;
					end
				end
				ST_SORT: begin
					if (sidx_q < fill_q) sidx_q <= sidx_q + 1'b1;
					else begin
						med_q <= sorted_q[PosW'(fill_q >> 1)];
						state_q <= ST_LEARN;
					end
				end
				ST_LEARN: begin
					if (fill_q == FillW'(WINDOW_DEPTH)) begin
						if (!cal_q) begin
							if (glow) begin
								llt_q <= now_q;
								if (boot_q == 0 || med_q < clow_q) clow_q <= med_q;
								if (boot_q == 0 || med_q > chigh_q) chigh_q <= med_q;
								if (boot_q == 3'(AcceptHits - 1)) begin
									rlow_q <= (boot_q == 0 || med_q < clow_q) ? med_q : clow_q;
									rhigh_q <= (boot_q == 0 || med_q > chigh_q) ? med_q : chigh_q;
									cal_q <= 1'b1; boot_q <= '0; clh_q <= '0; chh_q <= '0;
								end else boot_q <= boot_q + 1'b1;
							end
						end else begin
							if (smed < srl) begin
								if (glow) begin
									clm_q <= '0; llt_q <= now_q;
									if (clh_q == 3'(AcceptHits - 1)) begin
										rlow_q <= (med_q > clow_q) ? med_q : clow_q;
										clh_q <= '0;
									end else begin
										clh_q <= clh_q + 1'b1;
										if (clh_q == 0 || med_q > clow_q) clow_q <= med_q;
									end
								end
							end else if (clh_q != 0 && glow) begin
								llt_q <= now_q;
								if (clm_q == 5'(MissLimit - 1)) begin
									clh_q <= '0; clm_q <= '0;
								end else clm_q <= clm_q + 1'b1;
							end
							if (smed > srh) begin
								if (ghigh) begin
									chm_q <= '0; lht_q <= now_q;
									if (chh_q == 3'(AcceptHits - 1)) begin
										rhigh_q <= (med_q < chigh_q) ? med_q : chigh_q;
										chh_q <= '0;
									end else begin
										chh_q <= chh_q + 1'b1;
										if (chh_q == 0 || med_q < chigh_q) chigh_q <= med_q;
									end
								end
							end else if (chh_q != 0 && ghigh) begin
								lht_q <= now_q;
								if (chm_q == 5'(MissLimit - 1)) begin
									chh_q <= '0; chm_q <= '0;
								end else chm_q <= chm_q + 1'b1;
							end
						end
					end
					state_q <= ST_RANGE;
				end
				// range taken after the learning step has settled
				ST_RANGE: begin
					emin_q <= emin;
					span_q <= 17'(emax) - 17'(emin);
					state_q <= ST_MAP;
				end
				ST_MAP: begin
					neg_q <= num[17] ^ den[17];
					state_q <= (span_q != 17'd0) ? ST_MDIV : ST_EMA;
				end
				ST_MDIV: if (drsp.done) state_q <= ST_EMA;
				ST_EMA: begin
					lvl_q <= mlvl;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!svalid_q) begin
						smooth_q <= lvl_q; svalid_q <= 1'b1;
					end else
						smooth_q <= diff[14] ? smooth_q - step : smooth_q + step;
					state_q <= ST_RSV;
				end
				ST_RSV: begin
					olvl_q <= smooth_q;
					state_q <= rsv_on ? ST_RDIV : ST_VOL;
				end
				ST_RDIV: if (drsp.done) begin
					olvl_q <= (drsp.quotient > 36'd10000) ? 14'(FullScale) : drsp.quotient[13:0];
					state_q <= ST_VOL;
				end
				ST_VOL: state_q <= ST_VDIV;
				ST_VDIV: if (drsp.done) begin
					ovol_q <= drsp.quotient[15:0];
					m_tvalid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [15:0] vol;
	assign vol = (total_q != 16'd0) ? ovol_q : 16'd0;
	assign m_tdata = {7'd0, rhigh_q, rlow_q, cal_q, (smooth_q <= 14'(EmptyMark)),
		(total_q != 16'd0), vol, olvl_q};

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("accepted while busy");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(WINDOW_DEPTH)) else $error("fill overflow");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		smooth_q <= 14'(FullScale)) else $error("level out of range");
`endif
endmodule
